// ===== hdl/assert_macros.svh =====
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is high
`define VLRS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define VLRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/vlrs_pkg.sv =====
// package: constants, codes and word types of the record stack
package vlrs_pkg;

   localparam int STORE_BYTES  = 1024;
   localparam int MAX_ELEMENT  = 64;
   localparam int LENGTH_BYTES = 2;

   localparam int ADDR_W   = $clog2(STORE_BYTES);
   localparam int TOP_W    = $clog2(STORE_BYTES + 1);
   localparam int FIT_W    = TOP_W + 1;
   localparam int LEN_W    = 7;
   localparam int CNT_W    = LEN_W;
   localparam int STORED_W = 8 * LENGTH_BYTES;
   localparam int CMP_W    = (STORED_W > TOP_W) ? STORED_W : TOP_W;
   localparam int FREE_W   = 11;

   localparam logic [1:0] ACT_PUSH  = 2'd0;
   localparam logic [1:0] ACT_POP   = 2'd1;
   localparam logic [1:0] ACT_PEEK  = 2'd2;
   localparam logic [1:0] ACT_CLEAR = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]       action;
      logic [7:0]       push_byte;
      logic [LEN_W-1:0] element_length;
   } req_word_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [7:0]        pop_byte;
      logic              byte_valid;
      logic              last;
      logic              is_empty;
      logic [FREE_W-1:0] free_bytes;
   } rsp_word_type;

endpackage

// ===== hdl/vlrs_byte_ram.sv =====
// simple dual-port byte store with registered read data
module vlrs_byte_ram #(
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/variable_length_record_stack.sv =====
// top level: variable-length record stack over one byte store, sequenced
// push byte: result strobe in the cycle after accept, busy stays low;
//   the last byte of a stored record holds busy high while S_TRL writes the trailer
// pop/peek: S_TRD reads the trailer, S_CLAMP bounds it, S_CALC sizes the read, then
//   one byte a cycle from the single store read port; busy high through all of these
// clear and empty pop/peek: one result in the cycle after accept; results cannot be stalled
// reset (synchronous) empties the stack and drops a push in progress; store kept
module variable_length_record_stack
   import vlrs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_strobe,
   output rsp_word_type rsp_word
);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;  // takes a new word
   localparam logic [2:0] S_TRL   = 3'd1;  // writes the length trailer
   localparam logic [2:0] S_TRD   = 3'd2;  // reads the trailer, top byte first
   localparam logic [2:0] S_CLAMP = 3'd3;  // bounds the stored length
   localparam logic [2:0] S_CALC  = 3'd4;  // record base and byte count
   localparam logic [2:0] S_BYTES = 3'd5;  // streams the record bytes

   logic [2:0]          state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [TOP_W-1:0]    top_ff, top_in;
   // push in progress
   logic [LEN_W-1:0]    push_count_ff, push_count_in;
   logic                push_rej_ff, push_rej_in;
   logic [LEN_W-1:0]    push_len_ff, push_len_in;
   // trailer write
   logic [TOP_W-1:0]    trl_addr_ff, trl_addr_in;
   logic [LEN_W-1:0]    trl_len_ff, trl_len_in;
   // pop / peek
   logic                is_pop_ff, is_pop_in;
   logic [LEN_W-1:0]    req_len_ff, req_len_in;
   logic [STORED_W-1:0] stored_ff, stored_in;
   logic [LEN_W-1:0]    slen_ff, slen_in;
   logic [TOP_W-1:0]    base_ff, base_in;
   logic [LEN_W-1:0]    n_ff, n_in;
   // result register
   logic                rsp_strobe_ff, rsp_strobe_in;
   rsp_word_type        rsp_ff, rsp_in;

   // store port
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [7:0]          wr_data;
   logic [ADDR_W-1:0]   rd_addr;
   logic [7:0]          rd_data;

   // working values
   logic [TOP_W-1:0]    tpos;
   logic [FIT_W-1:0]    fit_sum;
   logic [LEN_W-1:0]    plen;
   logic                rej;
   logic                done;
   logic [LEN_W-1:0]    cnt_next;
   logic [CMP_W-1:0]    s1;
   logic [LEN_W-1:0]    n_calc;
   logic [1:0]          rsp_status;
   logic [7:0]          rsp_byte;
   logic                rsp_bvalid;
   logic                rsp_last;

   vlrs_byte_ram #(
      .DEPTH  (STORE_BYTES),
      .DATA_W (8)
   ) u_byte_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // start of the top record's trailer
   assign tpos = (top_ff >= TOP_W'(LENGTH_BYTES)) ? top_ff - TOP_W'(LENGTH_BYTES) : '0;

   // first push byte: record plus trailer must fit above the top
   assign fit_sum = FIT_W'(top_ff) + FIT_W'(req_word.element_length)
                    + FIT_W'(LENGTH_BYTES);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      top_in        = top_ff;
      push_count_in = push_count_ff;
      push_rej_in   = push_rej_ff;
      push_len_in   = push_len_ff;
      trl_addr_in   = trl_addr_ff;
      trl_len_in    = trl_len_ff;
      is_pop_in     = is_pop_ff;
      req_len_in    = req_len_ff;
      stored_in     = stored_ff;
      slen_in       = slen_ff;
      base_in       = base_ff;
      n_in          = n_ff;
      rsp_strobe_in = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_addr       = '0;
      plen          = push_len_ff;
      rej           = push_rej_ff;
      done          = 1'b0;
      cnt_next      = push_count_ff;
      s1            = '0;
      n_calc        = '0;
      rsp_status    = ST_OK;
      rsp_byte      = '0;
      rsp_bvalid    = 1'b0;
      rsp_last      = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_strobe_in = 1'b1;
               unique case (req_word.action)
                  ACT_PUSH: begin
                     // length and fit are settled on the first byte
                     if (push_count_ff == '0) begin
                        plen = req_word.element_length;
                        rej  = (req_word.element_length > LEN_W'(MAX_ELEMENT)) ||
                               (fit_sum > FIT_W'(STORE_BYTES));
                     end
                     if (plen == '0) begin
                        // zero-length record: trailer only
                        done = 1'b1;
                     end else begin
                        if (!rej) begin
                           wr_en   = 1'b1;
                           wr_addr = ADDR_W'(top_ff + TOP_W'(push_count_ff));
                           wr_data = req_word.push_byte;
                        end
                        cnt_next = push_count_ff + LEN_W'(1);
                        done     = (cnt_next >= plen);
                     end
                     if (done) begin
                        if (rej) begin
                           rsp_status = ST_FULL;
                        end else begin
                           // top moves now, the trailer bytes follow
                           trl_addr_in = top_ff + TOP_W'(plen);
                           trl_len_in  = plen;
                           top_in      = top_ff + TOP_W'(plen) + TOP_W'(LENGTH_BYTES);
                           cnt_in      = '0;
                           state_in    = S_TRL;
                        end
                        push_count_in = '0;
                        push_rej_in   = 1'b0;
                        push_len_in   = '0;
                     end else begin
                        push_count_in = cnt_next;
                        push_rej_in   = rej;
                        push_len_in   = plen;
                     end
                  end
                  ACT_CLEAR: begin
                     top_in        = '0;
                     push_count_in = '0;
                     push_rej_in   = 1'b0;
                     push_len_in   = '0;
                  end
                  ACT_POP, ACT_PEEK: begin
                     // any partial push is dropped
                     push_count_in = '0;
                     push_rej_in   = 1'b0;
                     push_len_in   = '0;
                     if (top_ff == '0) begin
                        rsp_status = ST_EMPTY;
                     end else begin
                        rsp_strobe_in = 1'b0;
                        is_pop_in     = (req_word.action == ACT_POP);
                        req_len_in    = (req_word.element_length > LEN_W'(MAX_ELEMENT)) ?
                                        LEN_W'(MAX_ELEMENT) : req_word.element_length;
                        stored_in     = '0;
                        cnt_in        = '0;
                        state_in      = S_TRD;
                     end
                  end
               endcase
            end
         end
         S_TRL: begin
            // length written low byte first
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(trl_addr_ff + TOP_W'(cnt_ff));
            wr_data = (cnt_ff == '0) ? 8'(trl_len_ff) : 8'h00;
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(LENGTH_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_TRD: begin
            // read issued one cycle, data shifted in the next
            if (cnt_ff < CNT_W'(LENGTH_BYTES)) begin
               rd_addr = ADDR_W'(tpos + TOP_W'(LENGTH_BYTES - 1) - TOP_W'(cnt_ff));
            end
            if (cnt_ff != '0) begin
               stored_in = (stored_ff << 8) | STORED_W'(rd_data);
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(LENGTH_BYTES)) begin
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            s1       = (CMP_W'(stored_ff) > CMP_W'(tpos)) ? CMP_W'(tpos) : CMP_W'(stored_ff);
            slen_in  = (s1 > CMP_W'(MAX_ELEMENT)) ? LEN_W'(MAX_ELEMENT) : LEN_W'(s1);
            state_in = S_CALC;
         end
         S_CALC: begin
            n_calc  = (req_len_ff < slen_ff) ? req_len_ff : slen_ff;
            n_in    = n_calc;
            base_in = tpos - TOP_W'(slen_ff);
            if (is_pop_ff) begin
               top_in = tpos - TOP_W'(slen_ff);
            end
            cnt_in = '0;
            if (n_calc == '0) begin
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               state_in = S_BYTES;
            end
         end
         S_BYTES: begin
            if (cnt_ff < n_ff) begin
               rd_addr = ADDR_W'(base_ff + TOP_W'(cnt_ff));
            end
            if (cnt_ff != '0) begin
               rsp_strobe_in = 1'b1;
               rsp_byte      = rd_data;
               rsp_bvalid    = 1'b1;
               rsp_last      = (cnt_ff == n_ff);
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == n_ff) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // every result shows the stack after this word's effect
      rsp_in.status     = rsp_status;
      rsp_in.pop_byte   = rsp_byte;
      rsp_in.byte_valid = rsp_bvalid;
      rsp_in.last       = rsp_last;
      rsp_in.is_empty   = (top_in == '0);
      rsp_in.free_bytes = FREE_W'(TOP_W'(STORE_BYTES) - top_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         top_ff        <= '0;
         push_count_ff <= '0;
         push_rej_ff   <= 1'b0;
         push_len_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         top_ff        <= top_in;
         push_count_ff <= push_count_in;
         push_rej_ff   <= push_rej_in;
         push_len_ff   <= push_len_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      trl_addr_ff <= trl_addr_in;
      trl_len_ff  <= trl_len_in;
      is_pop_ff   <= is_pop_in;
      req_len_ff  <= req_len_in;
      stored_ff   <= stored_in;
      slen_ff     <= slen_in;
      base_ff     <= base_in;
      n_ff        <= n_in;
      rsp_ff      <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

// ===== hdl/vlrs_checker.sv =====
// port-level checker for the record stack, bound to the top level
`include "assert_macros.svh"

module vlrs_checker
   import vlrs_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input req_word_type req_word,
   input logic         rsp_strobe,
   input rsp_word_type rsp_word
);

   `VLRS_ASSERT(a_push_one_result, clock, reset, start && !busy && req_word.action == ACT_PUSH |=> rsp_strobe && rsp_word.last, "push word gave no single result")
   `VLRS_ASSERT(a_error_alone, clock, reset, rsp_strobe && rsp_word.status != ST_OK |-> rsp_word.last && !rsp_word.byte_valid, "error result carries a byte or is not last")
   `VLRS_ASSERT(a_bytes_run_on, clock, reset, rsp_strobe && rsp_word.byte_valid && !rsp_word.last |=> rsp_strobe && rsp_word.byte_valid, "record byte run broken")
   `VLRS_ASSERT(a_empty_free, clock, reset, rsp_strobe |-> rsp_word.is_empty == (rsp_word.free_bytes == FREE_W'(STORE_BYTES)), "empty flag disagrees with free bytes")
   `VLRS_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_strobe && !busy, "activity right after reset")

endmodule

bind variable_length_record_stack vlrs_checker u_vlrs_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_word   (req_word),
   .rsp_strobe (rsp_strobe),
   .rsp_word   (rsp_word)
);

// ===== bench/tb_variable_length_record_stack.sv =====
// self-checking bench for the record stack: shadow stack predicts every result word
module tb_variable_length_record_stack
   import vlrs_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // dut ports
   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_word_type req_word;
   logic         rsp_strobe;
   rsp_word_type rsp_word;

   // shadow copy of the stack, updated as each word is accepted
   logic [7:0]  shadow_store [0:STORE_BYTES-1];
   int unsigned shadow_top;
   int unsigned shadow_count;
   int unsigned shadow_length;
   bit          shadow_rejected;

   // result words still owed by the dut, oldest first
   rsp_word_type due_words [$];

   int unsigned mismatch_count;
   int unsigned words_sent;
   // chance in a hundred that the sender sits out a cycle
   int unsigned idle_pct;

   variable_length_record_stack dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("variable_length_record_stack regression: fail");
      $finish;
   end

   // ---------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------

   // queue one result word; empty flag and free count reflect the state now
   function automatic void post_word(logic [1:0] st, logic [7:0] data, logic valid,
                                     logic fin);
      rsp_word_type w;
      w.status     = st;
      w.pop_byte   = data;
      w.byte_valid = valid;
      w.last       = fin;
      w.is_empty   = (shadow_top == 0);
      w.free_bytes = FREE_W'(STORE_BYTES - shadow_top);
      due_words.push_back(w);
   endfunction

   // apply one accepted request word to the shadow stack and queue its results
   function automatic void predict_stack_words(req_word_type w);
      int unsigned tpos;
      int unsigned stored;
      int unsigned base;
      int unsigned want_n;
      int unsigned n;
      int unsigned t;
      int unsigned i;
      bit          done;
      logic [1:0]  st;
      if (w.action == ACT_PUSH) begin
         st = ST_OK;
         // length and fit are decided on the first byte of a record
         if (shadow_count == 0) begin
            shadow_length   = w.element_length;
            shadow_rejected = (shadow_length > MAX_ELEMENT) ||
                              (shadow_length + LENGTH_BYTES > STORE_BYTES - shadow_top);
         end
         if (shadow_length == 0) begin
            // zero-length record completes at once, byte ignored
            done = 1'b1;
         end else begin
            if (!shadow_rejected && shadow_top + shadow_count < STORE_BYTES)
               shadow_store[shadow_top + shadow_count] = w.push_byte;
            shadow_count++;
            done = (shadow_count >= shadow_length);
         end
         if (done) begin
            if (shadow_rejected) begin
               st = ST_FULL;
            end else begin
               // length trailer, low byte first, then the top moves up
               t = shadow_top + shadow_length;
               for (i = 0; i < LENGTH_BYTES; i++)
                  if (t + i < STORE_BYTES)
                     shadow_store[t + i] = (i < 4) ? 8'(shadow_length >> (8 * i)) : 8'h00;
               shadow_top = t + LENGTH_BYTES;
            end
            shadow_count    = 0;
            shadow_rejected = 1'b0;
            shadow_length   = 0;
         end
         post_word(st, 8'h00, 1'b0, 1'b1);
      end else begin
         // any other action drops a record in progress
         shadow_count    = 0;
         shadow_rejected = 1'b0;
         shadow_length   = 0;
         if (w.action == ACT_CLEAR) begin
            shadow_top = 0;
            post_word(ST_OK, 8'h00, 1'b0, 1'b1);
         end else if (shadow_top == 0) begin
            post_word(ST_EMPTY, 8'h00, 1'b0, 1'b1);
         end else begin
            tpos   = (shadow_top >= LENGTH_BYTES) ? shadow_top - LENGTH_BYTES : 0;
            stored = 0;
            for (i = 0; i < LENGTH_BYTES; i++)
               stored |= int'(shadow_store[tpos + i]) << (8 * i);
            // clamp a trailer that could not be genuine
            if (stored > tpos)
               stored = tpos;
            if (stored > MAX_ELEMENT)
               stored = MAX_ELEMENT;
            base   = tpos - stored;
            want_n = (w.element_length > MAX_ELEMENT) ? MAX_ELEMENT : w.element_length;
            n      = (want_n < stored) ? want_n : stored;
            if (w.action == ACT_POP)
               shadow_top = base;
            if (n == 0) begin
               post_word(ST_OK, 8'h00, 1'b0, 1'b1);
            end else begin
               for (i = 0; i < n; i++)
                  post_word(ST_OK, shadow_store[base + i], 1'b1, (i + 1 == n));
            end
         end
      end
   endfunction

   // ---------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------

   task automatic report_mismatch(string what, logic [15:0] want, logic [15:0] got);
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %0h got %0h", $realtime, what, want, got);
   endtask

   // every strobed word is matched against the oldest owed word
   always @(posedge clock) begin : check_words
      rsp_word_type want;
      if (!reset && rsp_strobe) begin
         if (due_words.size() == 0) begin
            report_mismatch("unexpected word", 16'h0, 16'(rsp_word.pop_byte));
         end else begin
            want = due_words.pop_front();
            if (rsp_word.status !== want.status)
               report_mismatch("status", 16'(want.status), 16'(rsp_word.status));
            if (rsp_word.pop_byte !== want.pop_byte)
               report_mismatch("pop_byte", 16'(want.pop_byte), 16'(rsp_word.pop_byte));
            if (rsp_word.byte_valid !== want.byte_valid)
               report_mismatch("byte_valid", 16'(want.byte_valid), 16'(rsp_word.byte_valid));
            if (rsp_word.last !== want.last)
               report_mismatch("last", 16'(want.last), 16'(rsp_word.last));
            if (rsp_word.is_empty !== want.is_empty)
               report_mismatch("is_empty", 16'(want.is_empty), 16'(rsp_word.is_empty));
            if (rsp_word.free_bytes !== want.free_bytes)
               report_mismatch("free_bytes", 16'(want.free_bytes), 16'(rsp_word.free_bytes));
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------

   // drive one request word at the falling edge, hold until accepted
   task automatic send_word(logic [1:0] act, logic [7:0] data, logic [LEN_W-1:0] len);
      req_word_type w;
      w.action         = act;
      w.push_byte      = data;
      w.element_length = len;
      // random sender gaps
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start    <= 1'b1;
      req_word <= w;
      // accepted at the first rising edge with busy low
      do @(posedge clock); while (busy);
      predict_stack_words(w);
      words_sent++;
   endtask

   // whole record of random bytes; later bytes carry junk lengths the dut must ignore
   task automatic push_record(int unsigned len);
      int unsigned k;
      send_word(ACT_PUSH, 8'($urandom_range(255)), LEN_W'(len));
      for (k = 1; k < len; k++)
         send_word(ACT_PUSH, 8'($urandom_range(255)), LEN_W'($urandom_range(127)));
   endtask

   // pop, peek or clear picked at random
   task automatic send_random_read();
      case ($urandom_range(2))
         0: send_word(ACT_POP, 8'($urandom_range(255)), LEN_W'($urandom_range(127)));
         1: send_word(ACT_PEEK, 8'($urandom_range(255)), LEN_W'($urandom_range(127)));
         default: send_word(ACT_CLEAR, 8'($urandom_range(255)), LEN_W'($urandom_range(127)));
      endcase
   endtask

   // reads and clear on a stack that holds nothing
   task automatic test_empty_stack();
      send_word(ACT_POP, 8'h00, 7'd5);
      send_word(ACT_PEEK, 8'hFF, 7'd127);
      send_word(ACT_CLEAR, 8'h00, 7'd0);
   endtask

   // zero-length and short records, zero-byte reads, partial reads
   task automatic test_short_records();
      send_word(ACT_PUSH, 8'hFF, 7'd0);       // trailer only
      send_word(ACT_PEEK, 8'h00, 7'd9);       // nothing stored, no byte emitted
      send_word(ACT_POP, 8'h00, 7'd0);        // still removes the record
      send_word(ACT_PUSH, 8'hFF, 7'd1);
      send_word(ACT_PUSH, 8'h00, 7'd3);
      send_word(ACT_PUSH, 8'hA5, 7'd127);     // length on later bytes is ignored
      send_word(ACT_PUSH, 8'h5A, 7'd0);
      send_word(ACT_PEEK, 8'h00, 7'd0);       // zero requested
      send_word(ACT_PEEK, 8'h00, 7'd2);       // fewer than stored
      send_word(ACT_POP, 8'h00, 7'd3);
      send_word(ACT_POP, 8'h00, 7'd1);
      send_word(ACT_POP, 8'h00, 7'd1);        // empty again
   endtask

   // a read or clear in the middle of a record drops the partial record
   task automatic test_interrupted_push();
      send_word(ACT_PUSH, 8'h3C, 7'd1);
      send_word(ACT_PUSH, 8'h11, 7'd4);
      send_word(ACT_PUSH, 8'h22, 7'd4);
      send_word(ACT_PEEK, 8'h00, 7'd4);       // sees only the one-byte record
      send_word(ACT_PUSH, 8'h33, 7'd3);
      send_word(ACT_CLEAR, 8'h00, 7'd0);
      send_word(ACT_PUSH, 8'h44, 7'd2);
      send_word(ACT_POP, 8'h00, 7'd1);        // empty after the clear
      send_word(ACT_PUSH, 8'h55, 7'd2);
      send_word(ACT_PUSH, 8'h66, 7'd2);
      send_word(ACT_POP, 8'h00, 7'd2);
   endtask

   // maximum record, oversized requests, overlong push swallowed
   task automatic test_long_records();
      send_word(ACT_CLEAR, 8'h00, 7'd0);
      push_record(MAX_ELEMENT);
      send_word(ACT_PEEK, 8'h00, 7'd127);     // request capped at the maximum
      send_word(ACT_POP, 8'h00, 7'd100);
      send_word(ACT_POP, 8'h00, 7'd64);       // empty again
      push_record(MAX_ELEMENT + 1);           // reported full on its last byte
      send_word(ACT_POP, 8'h00, 7'd64);
   endtask

   // mostly whole records and reads, some broken records and noise
   task automatic test_random_traffic(int unsigned pct, int unsigned budget);
      int unsigned stop_at;
      int unsigned pick;
      int unsigned len;
      int unsigned cut;
      int unsigned k;
      idle_pct = pct;
      stop_at  = words_sent + budget;
      while (words_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            len = ($urandom_range(3) == 0) ? $urandom_range(13, 64) : $urandom_range(12);
            push_record(len);
         end else if (pick < 53) begin
            // broken record: a few bytes, then something else
            len = $urandom_range(2, 20);
            cut = $urandom_range(1, len - 1);
            for (k = 0; k < cut; k++)
               send_word(ACT_PUSH, 8'($urandom_range(255)), LEN_W'(len));
            send_random_read();
         end else if (pick < 55) begin
            push_record($urandom_range(65, 80));
         end else if (pick < 58) begin
            send_word(ACT_PUSH, 8'($urandom_range(255)), LEN_W'($urandom_range(127)));
         end else if (pick < 78) begin
            send_word(ACT_POP, 8'($urandom_range(255)),
                      LEN_W'($urandom_range(1) ? $urandom_range(64) : $urandom_range(127)));
         end else if (pick < 95) begin
            send_word(ACT_PEEK, 8'($urandom_range(255)),
                      LEN_W'($urandom_range(1) ? $urandom_range(64) : $urandom_range(127)));
         end else begin
            send_word(ACT_CLEAR, 8'($urandom_range(255)), LEN_W'($urandom_range(127)));
         end
      end
   endtask

   // ---------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_word        = '0;
      mismatch_count  = 0;
      words_sent      = 0;
      idle_pct        = 0;
      shadow_top      = 0;
      shadow_count    = 0;
      shadow_length   = 0;
      shadow_rejected = 1'b0;
      foreach (shadow_store[i])
         shadow_store[i] = 8'h00;

      // reset held, then released on a falling edge
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part back to back
      test_empty_stack();
      test_short_records();
      test_interrupted_push();
      test_long_records();

      // random part: no gaps, heavy gaps, light gaps
      test_random_traffic(0, 90);
      test_random_traffic(79, 80);
      test_random_traffic(10, 80);

      @(negedge clock);
      start <= 1'b0;

      // drain, then watch a little longer for stray words
      while (due_words.size() != 0)
         @(posedge clock);
      repeat (LENGTH_BYTES + 8) @(posedge clock);

      if (mismatch_count == 0)
         $display("variable_length_record_stack regression: pass");
      else
         $display("variable_length_record_stack regression: fail");
      $finish;
   end

endmodule
